// ===== rtl/core/ssbrem_pkg.sv =====
// Shared types and constants of the SSB resource element mapper.
package ssbrem_pkg;

   localparam int unsigned SYNC_LEN        = 127;
   localparam int unsigned DMRS_LEN        = 144;
   localparam int unsigned PBCH_LEN        = 432;
   localparam int unsigned SYNC_FIRST      = 56;
   localparam int unsigned SYNC_LAST       = 182;
   localparam int unsigned SYM2_LOW_END    = 48;
   localparam int unsigned SYM2_HIGH_START = 192;
   localparam int unsigned GRID_WIDTH      = 240;

   localparam int unsigned SYM2_LOW_DBASE  = 60;
   localparam int unsigned SYM2_LOW_PBASE  = 180;
   localparam int unsigned SYM2_HIGH_DBASE = 72;
   localparam int unsigned SYM2_HIGH_PBASE = 216;
   localparam int unsigned SYM3_DBASE      = 84;
   localparam int unsigned SYM3_PBASE      = 252;

   localparam int unsigned SYNC_ADDR_W   = 8;
   localparam int unsigned SYNC_DEPTH    = 256;
   localparam int unsigned SAMPLE_ADDR_W = 10;
   localparam int unsigned SAMPLE_DEPTH  = DMRS_LEN + PBCH_LEN;

   localparam logic [31:0] SYNC_LEVEL     = 32'd8192;
   localparam logic [31:0] SYNC_LEVEL_NEG = 32'd0 - SYNC_LEVEL;

   localparam logic [1:0] SIGN_ZERO = 2'd0;
   localparam logic [1:0] SIGN_POS  = 2'd1;
   localparam logic [1:0] SIGN_NEG  = 2'd2;

   typedef enum logic [2:0] {
      CMD_PSS  = 3'd0,
      CMD_SSS  = 3'd1,
      CMD_DMRS = 3'd2,
      CMD_PBCH = 3'd3,
      CMD_READ = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_EMPTY = 3'd0,
      KIND_PSS   = 3'd1,
      KIND_SSS   = 3'd2,
      KIND_DMRS  = 3'd3,
      KIND_PBCH  = 3'd4
   } kind_type;

   typedef struct packed {
      logic                     is_read;
      kind_type                 kind;
      logic                     sync_we;
      logic [1:0]               sync_wdata;
      logic [SYNC_ADDR_W-1:0]   sync_addr;
      logic                     sample_we;
      logic [SAMPLE_ADDR_W-1:0] sample_addr;
   } access_type;

endpackage

// ===== rtl/core/ssbrem_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module ssbrem_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 576
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ssbrem_addr.sv =====
// Command decode and grid-to-store address mapping.
module ssbrem_addr #(
   parameter int unsigned SAMPLE_WIDTH = 16
) (
   input  logic [2:0]              cmd,
   input  logic [8:0]              element_index,
   input  logic [SAMPLE_WIDTH-1:0] sample_real,
   input  logic [1:0]              symbol_number,
   input  logic [7:0]              subcarrier_number,
   input  logic [1:0]              cell_shift,
   output ssbrem_pkg::access_type  access
);

   logic       area;
   logic [7:0] kp;
   logic [7:0] dbase;
   logic [8:0] pbase;
   logic [8:0] skip;
   logic [7:0] sync_off;
   logic [1:0] sign;

   always_comb begin
      if (sample_real == '0) begin
         sign = ssbrem_pkg::SIGN_ZERO;
      end else if (sample_real[SAMPLE_WIDTH-1]) begin
         sign = ssbrem_pkg::SIGN_NEG;
      end else begin
         sign = ssbrem_pkg::SIGN_POS;
      end
   end

   assign sync_off = subcarrier_number - 8'(ssbrem_pkg::SYNC_FIRST);

   always_comb begin
      access            = '0;
      access.kind       = ssbrem_pkg::KIND_EMPTY;
      access.sync_wdata = sign;
      area              = 1'b0;
      kp                = subcarrier_number;
      dbase             = '0;
      pbase             = '0;
      skip              = '0;
      unique case (ssbrem_pkg::cmd_type'(cmd))
         ssbrem_pkg::CMD_PSS: begin
            access.sync_we   = element_index < 9'(ssbrem_pkg::SYNC_LEN);
            access.sync_addr = {1'b0, element_index[6:0]};
         end
         ssbrem_pkg::CMD_SSS: begin
            access.sync_we   = element_index < 9'(ssbrem_pkg::SYNC_LEN);
            access.sync_addr = {1'b1, element_index[6:0]};
         end
         ssbrem_pkg::CMD_DMRS: begin
            access.sample_we   = element_index < 9'(ssbrem_pkg::DMRS_LEN);
            access.sample_addr = 10'(element_index);
         end
         ssbrem_pkg::CMD_PBCH: begin
            access.sample_we   = element_index < 9'(ssbrem_pkg::PBCH_LEN);
            access.sample_addr = 10'(element_index) + 10'(ssbrem_pkg::DMRS_LEN);
         end
         ssbrem_pkg::CMD_READ: begin
            access.is_read = 1'b1;
            if (subcarrier_number < 8'(ssbrem_pkg::GRID_WIDTH)) begin
               unique case (symbol_number)
                  2'd0: begin
                     if (subcarrier_number >= 8'(ssbrem_pkg::SYNC_FIRST) &&
                         subcarrier_number <= 8'(ssbrem_pkg::SYNC_LAST)) begin
                        access.kind      = ssbrem_pkg::KIND_PSS;
                        access.sync_addr = {1'b0, sync_off[6:0]};
                     end
                  end
                  2'd1: begin
                     area = 1'b1;
                  end
                  2'd3: begin
                     area  = 1'b1;
                     dbase = 8'(ssbrem_pkg::SYM3_DBASE);
                     pbase = 9'(ssbrem_pkg::SYM3_PBASE);
                  end
                  default: begin
                     if (subcarrier_number < 8'(ssbrem_pkg::SYM2_LOW_END)) begin
                        area  = 1'b1;
                        dbase = 8'(ssbrem_pkg::SYM2_LOW_DBASE);
                        pbase = 9'(ssbrem_pkg::SYM2_LOW_PBASE);
                     end else if (subcarrier_number >=
                                  8'(ssbrem_pkg::SYM2_HIGH_START)) begin
                        area  = 1'b1;
                        kp    = subcarrier_number - 8'(ssbrem_pkg::SYM2_HIGH_START);
                        dbase = 8'(ssbrem_pkg::SYM2_HIGH_DBASE);
                        pbase = 9'(ssbrem_pkg::SYM2_HIGH_PBASE);
                     end else if (subcarrier_number >= 8'(ssbrem_pkg::SYNC_FIRST) &&
                                  subcarrier_number <= 8'(ssbrem_pkg::SYNC_LAST)) begin
                        access.kind      = ssbrem_pkg::KIND_SSS;
                        access.sync_addr = {1'b1, sync_off[6:0]};
                     end
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
      if (area) begin
         skip = {1'b0, kp} + 9'd3 - {7'b0, cell_shift};
         if (kp[1:0] == cell_shift) begin
            access.kind        = ssbrem_pkg::KIND_DMRS;
            access.sample_addr = 10'(dbase) + 10'(kp[7:2]);
         end else begin
            access.kind        = ssbrem_pkg::KIND_PBCH;
            access.sample_addr = 10'(ssbrem_pkg::DMRS_LEN) + 10'(pbase) + 10'(kp)
                                 - 10'(skip[8:2]);
         end
      end
   end

endmodule

// ===== rtl/core/ssb_resource_element_mapper.sv =====
// SSB resource element mapper top level: source stores, read pipeline, output register.
//
//   channel | dir | handshake             | tdata / tuser
//   req     | in  | req_tvalid/req_tready | index, real, imag, symbol, subcarrier / cmd
//   rsp     | out | rsp_tvalid/rsp_tready | grid_real, grid_imag / source_kind
//   csr     | in  | csr_wr_en             | csr_wr_data = physical_cell_id
//
// One word is accepted per cycle while req_tready is high; loads produce no response.
// A read is answered through the store read port register, then the output register.
// Reset clears the pipeline and the cell id; the stores need no clearing pass.
// A stalled response holds the read stage, and a held read stage holds req_tready low.
module ssb_resource_element_mapper #(
   parameter int unsigned SAMPLE_WIDTH = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // element_index, sample_real, sample_imag, symbol_number, subcarrier_number
   input  logic [((19 + 2 * SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   // cmd
   input  logic [2:0]                                 req_tuser,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // grid_real, grid_imag
   output logic [((2 * SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
   // source_kind
   output logic [2:0]                                 rsp_tuser,
   input  logic                                       csr_wr_en,
   input  logic [9:0]                                 csr_wr_data
);

   localparam int unsigned SW       = SAMPLE_WIDTH;
   localparam int unsigned RE_LO    = 9;
   localparam int unsigned IM_LO    = RE_LO + SW;
   localparam int unsigned SYM_LO   = IM_LO + SW;
   localparam int unsigned SC_LO    = SYM_LO + 2;
   localparam int unsigned RSP_W    = ((2 * SW + 7) / 8) * 8;

   localparam logic [SW-1:0] LEVEL_POS = ssbrem_pkg::SYNC_LEVEL[SW-1:0];
   localparam logic [SW-1:0] LEVEL_NEG = ssbrem_pkg::SYNC_LEVEL_NEG[SW-1:0];

   logic [8:0]    element_index;
   logic [SW-1:0] sample_real;
   logic [SW-1:0] sample_imag;
   logic [1:0]    symbol_number;
   logic [7:0]    subcarrier_number;

   ssbrem_pkg::access_type access;
   ssbrem_pkg::kind_type   s1_kind_ff, s1_kind_in;

   logic          accept;
   logic          out_free;
   logic          read_go;
   logic [1:0]    cell_shift_ff, cell_shift_in;
   logic          s1_valid_ff, s1_valid_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] rsp_real_ff, rsp_real_in;
   logic [SW-1:0] rsp_imag_ff, rsp_imag_in;
   logic [2:0]    rsp_kind_ff, rsp_kind_in;
   logic [1:0]    sync_rd_data;
   logic [2*SW-1:0] sample_rd_data;

   assign element_index     = req_tdata[8:0];
   assign sample_real       = req_tdata[RE_LO +: SW];
   assign sample_imag       = req_tdata[IM_LO +: SW];
   assign symbol_number     = req_tdata[SYM_LO +: 2];
   assign subcarrier_number = req_tdata[SC_LO +: 8];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;
   assign read_go    = accept && access.is_read;

   ssbrem_addr #(
      .SAMPLE_WIDTH(SW)
   ) u_addr (
      .cmd              (req_tuser),
      .element_index    (element_index),
      .sample_real      (sample_real),
      .symbol_number    (symbol_number),
      .subcarrier_number(subcarrier_number),
      .cell_shift       (cell_shift_ff),
      .access           (access)
   );

   ssbrem_ram #(
      .WIDTH(2),
      .DEPTH(ssbrem_pkg::SYNC_DEPTH)
   ) u_sync_ram (
      .clock  (clock),
      .wr_en  (accept && access.sync_we),
      .wr_addr(access.sync_addr),
      .wr_data(access.sync_wdata),
      .rd_en  (read_go),
      .rd_addr(access.sync_addr),
      .rd_data(sync_rd_data)
   );

   ssbrem_ram #(
      .WIDTH(2 * SW),
      .DEPTH(ssbrem_pkg::SAMPLE_DEPTH)
   ) u_sample_ram (
      .clock  (clock),
      .wr_en  (accept && access.sample_we),
      .wr_addr(access.sample_addr),
      .wr_data({sample_imag, sample_real}),
      .rd_en  (read_go),
      .rd_addr(access.sample_addr),
      .rd_data(sample_rd_data)
   );

   always_comb begin
      cell_shift_in = csr_wr_en ? csr_wr_data[1:0] : cell_shift_ff;

      s1_valid_in = s1_valid_ff && !out_free;
      s1_kind_in  = s1_kind_ff;
      if (read_go) begin
         s1_valid_in = 1'b1;
         s1_kind_in  = access.kind;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_real_in  = rsp_real_ff;
      rsp_imag_in  = rsp_imag_ff;
      rsp_kind_in  = rsp_kind_ff;
      if (s1_valid_ff && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = s1_kind_ff;
         rsp_real_in  = '0;
         rsp_imag_in  = '0;
         case (s1_kind_ff) inside
            ssbrem_pkg::KIND_PSS, ssbrem_pkg::KIND_SSS: begin
               if (sync_rd_data == ssbrem_pkg::SIGN_POS) begin
                  rsp_real_in = LEVEL_POS;
               end else if (sync_rd_data == ssbrem_pkg::SIGN_NEG) begin
                  rsp_real_in = LEVEL_NEG;
               end
            end
            ssbrem_pkg::KIND_DMRS, ssbrem_pkg::KIND_PBCH: begin
               rsp_real_in = sample_rd_data[SW-1:0];
               rsp_imag_in = sample_rd_data[2*SW-1:SW];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_shift_ff <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cell_shift_ff <= cell_shift_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      s1_kind_ff  <= s1_kind_in;
      rsp_real_ff <= rsp_real_in;
      rsp_imag_ff <= rsp_imag_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_imag_ff, rsp_real_ff});
   assign rsp_tuser  = rsp_kind_ff;

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("input accepted while read stage is blocked");

   a_read_enters_stage: assert property (@(posedge clock) disable iff (reset)
      read_go |=> s1_valid_ff)
      else $error("accepted read did not enter read stage");

   a_stage_drains: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_free |=> rsp_tvalid)
      else $error("read stage advanced without a response");

   a_sync_no_imag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ssbrem_pkg::KIND_EMPTY ||
                     rsp_tuser == ssbrem_pkg::KIND_PSS ||
                     rsp_tuser == ssbrem_pkg::KIND_SSS) |-> rsp_imag_ff == '0)
      else $error("nonzero imaginary part for sync or empty element");

endmodule

// ===== test/ssb_resource_element_mapper_tb.sv =====
// Self-checking testbench of the SSB resource element mapper: loads, grid reads, cell id phases.
module ssb_resource_element_mapper_tb;

   localparam int unsigned REQ_W       = 56;
   localparam int unsigned RSP_W       = 32;
   localparam int unsigned MAX_GAP     = 8;
   localparam int unsigned LONG_HOLD   = 80;
   localparam int unsigned SETTLE      = 6;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned PHASE_WORDS = 155;
   localparam int unsigned INDEX_MAX   = 511;
   localparam int unsigned SC_MAX      = 255;
   localparam int unsigned CELL_ID_MAX = 1007;

   typedef struct {
      logic [2:0]  cmd;
      logic [8:0]  index;
      logic [15:0] re;
      logic [15:0] im;
      logic [1:0]  sym;
      logic [7:0]  sc;
   } req_word_type;

   typedef struct {
      logic [15:0]          re;
      logic [15:0]          im;
      ssbrem_pkg::kind_type kind;
   } grid_elem_type;

   class grid_scoreboard_type;
      logic [1:0]    pss_sign[ssbrem_pkg::SYNC_LEN];
      logic [1:0]    sss_sign[ssbrem_pkg::SYNC_LEN];
      logic [31:0]   dmrs_word[ssbrem_pkg::DMRS_LEN];
      logic [31:0]   pbch_word[ssbrem_pkg::PBCH_LEN];
      bit            pss_set[ssbrem_pkg::SYNC_LEN];
      bit            sss_set[ssbrem_pkg::SYNC_LEN];
      bit            dmrs_set[ssbrem_pkg::DMRS_LEN];
      bit            pbch_set[ssbrem_pkg::PBCH_LEN];
      logic [9:0]    cell_id;
      grid_elem_type expected_q[$];
      int unsigned   loads, reads, ignored, checked, mismatches;

      function new();
         cell_id = '0;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void split(input int unsigned k, input int unsigned v,
                          input int unsigned dbase, input int unsigned pbase,
                          output ssbrem_pkg::kind_type kind, output int unsigned idx);
         if ((k % 4) == v) begin
            kind = ssbrem_pkg::KIND_DMRS;
            idx  = dbase + k / 4;
         end else begin
            kind = ssbrem_pkg::KIND_PBCH;
            idx  = pbase + k - (k + 3 - v) / 4;
         end
      endfunction

      // map a grid position to its source and entry
      function void place(input logic [1:0] sym, input logic [7:0] sc,
                          output ssbrem_pkg::kind_type kind, output int unsigned idx);
         int unsigned k;
         int unsigned v;
         k    = 32'(sc);
         v    = 32'(cell_id[1:0]);
         kind = ssbrem_pkg::KIND_EMPTY;
         idx  = 0;
         if (k >= ssbrem_pkg::GRID_WIDTH) return;
         case (sym)
            2'd0: begin
               if (k >= ssbrem_pkg::SYNC_FIRST && k <= ssbrem_pkg::SYNC_LAST) begin
                  kind = ssbrem_pkg::KIND_PSS;
                  idx  = k - ssbrem_pkg::SYNC_FIRST;
               end
            end
            2'd1: split(k, v, 0, 0, kind, idx);
            2'd3: split(k, v, ssbrem_pkg::SYM3_DBASE, ssbrem_pkg::SYM3_PBASE, kind, idx);
            default: begin
               if (k < ssbrem_pkg::SYM2_LOW_END)
                  split(k, v, ssbrem_pkg::SYM2_LOW_DBASE, ssbrem_pkg::SYM2_LOW_PBASE,
                        kind, idx);
               else if (k >= ssbrem_pkg::SYM2_HIGH_START)
                  split(k - ssbrem_pkg::SYM2_HIGH_START, v, ssbrem_pkg::SYM2_HIGH_DBASE,
                        ssbrem_pkg::SYM2_HIGH_PBASE, kind, idx);
               else if (k >= ssbrem_pkg::SYNC_FIRST && k <= ssbrem_pkg::SYNC_LAST) begin
                  kind = ssbrem_pkg::KIND_SSS;
                  idx  = k - ssbrem_pkg::SYNC_FIRST;
               end
            end
         endcase
      endfunction

      function bit readable(input logic [1:0] sym, input logic [7:0] sc);
         ssbrem_pkg::kind_type kind;
         int unsigned          idx;
         place(sym, sc, kind, idx);
         case (kind)
            ssbrem_pkg::KIND_PSS:  return pss_set[idx];
            ssbrem_pkg::KIND_SSS:  return sss_set[idx];
            ssbrem_pkg::KIND_DMRS: return dmrs_set[idx];
            ssbrem_pkg::KIND_PBCH: return pbch_set[idx];
            default:               return 1'b1;
         endcase
      endfunction

      function logic [1:0] sign_of(input logic [15:0] re);
         if (re == '0) return ssbrem_pkg::SIGN_ZERO;
         if (re[15]) return ssbrem_pkg::SIGN_NEG;
         return ssbrem_pkg::SIGN_POS;
      endfunction

      function logic [15:0] sync_level(input logic [1:0] code);
         if (code == ssbrem_pkg::SIGN_POS) return ssbrem_pkg::SYNC_LEVEL[15:0];
         if (code == ssbrem_pkg::SIGN_NEG) return ssbrem_pkg::SYNC_LEVEL_NEG[15:0];
         return '0;
      endfunction

      function void note_request(input req_word_type w);
         grid_elem_type e;
         int unsigned   idx;
         idx = 32'(w.index);
         case (w.cmd)
            ssbrem_pkg::CMD_PSS: if (idx < ssbrem_pkg::SYNC_LEN) begin
               pss_sign[idx] = sign_of(w.re);
               pss_set[idx]  = 1'b1;
            end
            ssbrem_pkg::CMD_SSS: if (idx < ssbrem_pkg::SYNC_LEN) begin
               sss_sign[idx] = sign_of(w.re);
               sss_set[idx]  = 1'b1;
            end
            ssbrem_pkg::CMD_DMRS: if (idx < ssbrem_pkg::DMRS_LEN) begin
               dmrs_word[idx] = {w.im, w.re};
               dmrs_set[idx]  = 1'b1;
            end
            ssbrem_pkg::CMD_PBCH: if (idx < ssbrem_pkg::PBCH_LEN) begin
               pbch_word[idx] = {w.im, w.re};
               pbch_set[idx]  = 1'b1;
            end
            ssbrem_pkg::CMD_READ: begin
               place(w.sym, w.sc, e.kind, idx);
               e.re = '0;
               e.im = '0;
               case (e.kind)
                  ssbrem_pkg::KIND_PSS:  e.re = sync_level(pss_sign[idx]);
                  ssbrem_pkg::KIND_SSS:  e.re = sync_level(sss_sign[idx]);
                  ssbrem_pkg::KIND_DMRS: {e.im, e.re} = dmrs_word[idx];
                  ssbrem_pkg::KIND_PBCH: {e.im, e.re} = pbch_word[idx];
                  default: ;
               endcase
               expected_q.push_back(e);
               reads++;
               return;
            end
            default: begin
               ignored++;
               return;
            end
         endcase
         if ((w.cmd == ssbrem_pkg::CMD_PSS || w.cmd == ssbrem_pkg::CMD_SSS) &&
             idx >= ssbrem_pkg::SYNC_LEN) ignored++;
         else if (w.cmd == ssbrem_pkg::CMD_DMRS && idx >= ssbrem_pkg::DMRS_LEN) ignored++;
         else if (w.cmd == ssbrem_pkg::CMD_PBCH && idx >= ssbrem_pkg::PBCH_LEN) ignored++;
         else loads++;
      endfunction

      function void check_response(input logic [15:0] re, input logic [15:0] im,
                                   input logic [2:0] kind);
         grid_elem_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected grid word re=%h im=%h kind=%0d", $time, re, im, kind);
            mismatches++;
            return;
         end
         e = expected_q.pop_front();
         checked++;
         if (re !== e.re) begin
            $display("%0t: grid_real expected %h actual %h", $time, e.re, re);
            mismatches++;
         end
         if (im !== e.im) begin
            $display("%0t: grid_imag expected %h actual %h", $time, e.im, im);
            mismatches++;
         end
         if (kind !== e.kind) begin
            $display("%0t: source_kind expected %0d actual %0d", $time, e.kind, kind);
            mismatches++;
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic [2:0]       req_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic [2:0]       rsp_tuser;
   logic             csr_wr_en;
   logic [9:0]       csr_wr_data;

   grid_scoreboard_type board;
   bit                  idle_off;
   bit                  long_hold_request;
   int unsigned         cycle_count;
   int unsigned         id_settings;

   ssb_resource_element_mapper u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL ssb_resource_element_mapper");
         $finish;
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_word(input req_word_type w);
      int unsigned gap;
      gap = idle_off ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= w.cmd;
      req_tdata  <= REQ_W'({w.sc, w.sym, w.im, w.re, w.index});
      do @(posedge clock); while (!req_tready);
      board.note_request(w);
      @(negedge clock);
   endtask

   task automatic send(input logic [2:0] cmd, input int unsigned index,
                       input logic [15:0] re, input logic [15:0] im,
                       input int unsigned sym, input int unsigned sc);
      req_word_type w;
      w.cmd   = cmd;
      w.index = 9'(index);
      w.re    = re;
      w.im    = im;
      w.sym   = 2'(sym);
      w.sc    = 8'(sc);
      send_word(w);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic set_cell_id(input logic [9:0] id);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= id;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      board.cell_id = id;
      id_settings++;
   endtask

   task automatic random_read(output req_word_type w);
      int unsigned tries;
      w.cmd   = ssbrem_pkg::CMD_READ;
      w.index = 9'($urandom_range(0, INDEX_MAX));
      w.re    = 16'($urandom);
      w.im    = 16'($urandom);
      tries   = 0;
      do begin
         w.sym = 2'($urandom_range(0, 3));
         w.sc  = 8'($urandom_range(0, SC_MAX));
         tries++;
      end while (!board.readable(w.sym, w.sc) && tries < 16);
      if (!board.readable(w.sym, w.sc))
         w.sc = 8'($urandom_range(ssbrem_pkg::GRID_WIDTH, SC_MAX));
   endtask

   task automatic random_word(output req_word_type w);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick >= 45) begin
         random_read(w);
         return;
      end
      w.re  = 16'($urandom);
      w.im  = 16'($urandom);
      w.sym = 2'($urandom_range(0, 3));
      w.sc  = 8'($urandom_range(0, SC_MAX));
      if (pick < 2) begin
         w.cmd   = 3'(ssbrem_pkg::CMD_READ) + 3'($urandom_range(1, 3));
         w.index = 9'($urandom_range(0, INDEX_MAX));
         return;
      end
      w.cmd = 3'($urandom_range(ssbrem_pkg::CMD_PSS, ssbrem_pkg::CMD_PBCH));
      case (w.cmd) inside
         ssbrem_pkg::CMD_PSS, ssbrem_pkg::CMD_SSS:
            w.index = (pick < 5) ? 9'($urandom_range(ssbrem_pkg::SYNC_LEN, INDEX_MAX))
                                 : 9'($urandom_range(0, ssbrem_pkg::SYNC_LEN - 1));
         ssbrem_pkg::CMD_DMRS:
            w.index = (pick < 5) ? 9'($urandom_range(ssbrem_pkg::DMRS_LEN, INDEX_MAX))
                                 : 9'($urandom_range(0, ssbrem_pkg::DMRS_LEN - 1));
         default:
            w.index = (pick < 5) ? 9'($urandom_range(ssbrem_pkg::PBCH_LEN, INDEX_MAX))
                                 : 9'($urandom_range(0, ssbrem_pkg::PBCH_LEN - 1));
      endcase
   endtask

   initial begin
      logic [15:0] re, im;
      logic [2:0]  kind;
      int unsigned stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = long_hold_request ? LONG_HOLD : (idle_off ? 0 : $urandom_range(0, MAX_GAP));
         long_hold_request = 1'b0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         re   = rsp_tdata[15:0];
         im   = rsp_tdata[31:16];
         kind = rsp_tuser;
         board.check_response(re, im, kind);
         @(negedge clock);
      end
   end

   initial begin
      logic [9:0]   phase_ids[6];
      req_word_type w;
      board       = new();
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      phase_ids   = '{10'(CELL_ID_MAX), 10'd1, 10'd514, 10'd0, 10'd0, 10'd0};
      phase_ids[4] = 10'($urandom_range(0, CELL_ID_MAX));
      phase_ids[5] = 10'($urandom_range(0, CELL_ID_MAX));
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      set_cell_id('0);
      send(ssbrem_pkg::CMD_PSS,  0, 16'h7FFF, 16'h1234, 0, 0);
      send(ssbrem_pkg::CMD_PSS,  1, 16'h0000, 16'hFFFF, 3, SC_MAX);
      send(ssbrem_pkg::CMD_PSS,  ssbrem_pkg::SYNC_LEN - 1, 16'h8000, 16'h0000, 0, 0);
      send(ssbrem_pkg::CMD_SSS,  0, 16'h0001, 16'h8000, 0, 0);
      send(ssbrem_pkg::CMD_SSS,  ssbrem_pkg::SYNC_LEN - 1, 16'hFFFF, 16'h7FFF, 0, 0);
      send(ssbrem_pkg::CMD_DMRS, 0, 16'h8000, 16'h7FFF, 0, 0);
      send(ssbrem_pkg::CMD_DMRS, ssbrem_pkg::DMRS_LEN - 1, 16'h7FFF, 16'h8000, 0, 0);
      send(ssbrem_pkg::CMD_PBCH, 0, 16'hFFFF, 16'h0001, 0, 0);
      send(ssbrem_pkg::CMD_PBCH, ssbrem_pkg::PBCH_LEN - 1, 16'h0001, 16'hFFFF, 0, 0);
      send(ssbrem_pkg::CMD_PSS,  ssbrem_pkg::SYNC_LEN, 16'h8000, 16'h0000, 0, 0);
      send(ssbrem_pkg::CMD_DMRS, ssbrem_pkg::DMRS_LEN, 16'h1111, 16'h2222, 0, 0);
      send(ssbrem_pkg::CMD_PBCH, INDEX_MAX, 16'h3333, 16'h4444, 0, 0);
      send(3'(ssbrem_pkg::CMD_READ) + 3'd1, 0, 16'h0, 16'h0, 0, 56);
      send(3'(ssbrem_pkg::CMD_READ) + 3'd3, INDEX_MAX, 16'hFFFF, 16'hFFFF, 3, SC_MAX);
      send(ssbrem_pkg::CMD_READ, 0, 16'h0, 16'h0, 0, ssbrem_pkg::SYNC_FIRST);
      send(ssbrem_pkg::CMD_READ, 0, 16'h0, 16'h0, 0, ssbrem_pkg::SYNC_FIRST + 1);
      send(ssbrem_pkg::CMD_READ, 0, 16'h0, 16'h0, 0, ssbrem_pkg::SYNC_LAST);
      send(ssbrem_pkg::CMD_READ, 0, 16'h0, 16'h0, 2, ssbrem_pkg::SYNC_FIRST);
      send(ssbrem_pkg::CMD_READ, 0, 16'h0, 16'h0, 2, ssbrem_pkg::SYNC_LAST);
      send(ssbrem_pkg::CMD_READ, 0, 16'h0, 16'h0, 0, 0);
      send(ssbrem_pkg::CMD_READ, 0, 16'h0, 16'h0, 2, 50);
      send(ssbrem_pkg::CMD_READ, 0, 16'h0, 16'h0, 1, SC_MAX);
      send(ssbrem_pkg::CMD_READ, 0, 16'h0, 16'h0, 1, 0);
      send(ssbrem_pkg::CMD_READ, 0, 16'h0, 16'h0, 1, 1);
      send(ssbrem_pkg::CMD_READ, 0, 16'h0, 16'h0, 3, 236);
      send(ssbrem_pkg::CMD_READ, 0, 16'h0, 16'h0, 3, ssbrem_pkg::GRID_WIDTH - 1);

      foreach (phase_ids[p]) begin
         set_cell_id(phase_ids[p]);
         if (p == 1) begin
            // stall the response side while reads arrive back to back
            idle_off          = 1'b1;
            long_hold_request = 1'b1;
            repeat (40) begin
               random_read(w);
               send_word(w);
            end
            idle_off = 1'b0;
         end
         for (int unsigned n = 0; n < PHASE_WORDS; n++) begin
            idle_off = (n >= 60 && n < 90);
            if (n == PHASE_WORDS / 2) wait_idle();
            random_word(w);
            send_word(w);
         end
         idle_off = 1'b0;
      end

      wait_idle();
      $display("Run covered %0d loads, %0d grid reads (%0d checked), %0d ignored words,",
               board.loads, board.reads, board.checked, board.ignored);
      $display("over %0d cell id settings with long response stall and back-to-back bursts.",
               id_settings);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("PASS ssb_resource_element_mapper");
      else
         $display("FAIL ssb_resource_element_mapper");
      $finish;
   end

endmodule

// ===== ssb_resource_element_mapper.f =====
rtl/core/ssbrem_pkg.sv
rtl/core/ssbrem_ram.sv
rtl/core/ssbrem_addr.sv
rtl/core/ssb_resource_element_mapper.sv
test/ssb_resource_element_mapper_tb.sv
